// ===== hw/rtl/tile_blit_rect_calc_top_assert.svh =====
// assertion macros for the tile rectangle calculator
// each macro expects clk and rst_n in scope
`ifndef TILE_BLIT_RECT_CALC_TOP_ASSERT_SVH
`define TILE_BLIT_RECT_CALC_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition implies property in the same cycle
`define TBRC_ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// condition implies property in the next cycle
`define TBRC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define TBRC_ASSERT_SAME(label, cond, prop, msg)
`define TBRC_ASSERT_NEXT(label, cond, prop, msg)

`endif

`endif

// ===== hw/rtl/tbrc_pkg.sv =====
`default_nettype none

package tbrc_pkg;

    // widths fixed by the field formats
    localparam int unsigned ID_W        = 29;
    localparam int unsigned COLS_W      = 16;
    localparam int unsigned PIX_W       = 12;
    localparam int unsigned PITCH_W     = PIX_W + 1;
    localparam int unsigned MUL_A_W     = 32;
    localparam int unsigned PROD_W      = MUL_A_W + PITCH_W;
    localparam int unsigned SRC_X_W     = 32;
    localparam int unsigned SRC_Y_W     = 43;
    localparam int unsigned DST_W       = 28;
    localparam int unsigned CFG_ADDR_W  = 5;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam int unsigned DEF_ROW_COUNT_BITS = 16;

    localparam logic [31:0] ID_MASK = 32'h1FFF_FFFF;

    // divider runs one quotient bit per cycle
    localparam int unsigned DIV_STEPS = ID_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // multiplier step codes
    localparam int unsigned MUL_CNT_W = 3;
    localparam logic [MUL_CNT_W-1:0] MUL_SRC_Y = 3'd0;
    localparam logic [MUL_CNT_W-1:0] MUL_SRC_X = 3'd1;
    localparam logic [MUL_CNT_W-1:0] MUL_DST_X = 3'd2;
    localparam logic [MUL_CNT_W-1:0] MUL_DST_Y = 3'd3;
    localparam logic [MUL_CNT_W-1:0] MUL_FLUSH = 3'd4;

    // register map, word index
    typedef enum logic [2:0] {
        REG_FIRST_TILE_ID = 3'd0,
        REG_TILE_TOTAL    = 3'd1,
        REG_SET_COLUMNS   = 3'd2,
        REG_TILE_W        = 3'd3,
        REG_TILE_H        = 3'd4,
        REG_IMAGE_MARGIN  = 3'd5,
        REG_TILE_GAP      = 3'd6,
        REG_LAYER_COLS    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [ID_W-1:0]   first_tile_id;
        logic [ID_W-1:0]   tile_total;
        logic [COLS_W-1:0] set_columns;
        logic [PIX_W-1:0]  tile_w;
        logic [PIX_W-1:0]  tile_h;
        logic [PIX_W-1:0]  image_margin;
        logic [PIX_W-1:0]  tile_gap;
        logic [COLS_W-1:0] layer_cols;
    } cfg_t;

    typedef struct packed {
        logic [31:0] cell_word;
        logic        final_cell;
    } cell_in_t;

    typedef struct packed {
        logic               draw;
        logic [SRC_X_W-1:0] src_x;
        logic [SRC_Y_W-1:0] src_y;
        logic [DST_W-1:0]   dst_x;
        logic [DST_W-1:0]   dst_y;
        logic               end_of_layer;
    } rect_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic mul_run;
        logic finish;
    } seq_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tile_blit_rect_calc_top.sv =====
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+-------------------------------
// cell      | in        | cell_valid / cell_stall  | cell_word, final_cell
// rect      | out       | rect_valid / rect_stall  | draw, src_x/y, dst_x/y, end_of_layer
// apb cfg   | in        | psel / penable / pready  | paddr, pwdata, prdata
//
// a drawn cell is accepted, passes the bit-serial tile index divider (a 29-bit quotient),
// then the shared multiplier (four products plus drain), and is loaded into the output
// register; a skipped cell goes from accept straight to loading the output register
// the next cell is taken while the previous result still waits in the output register
// a stalled output holds the finished result and the sequencer waits before loading
// reset clears the configuration to defaults, the column and row counters and the control

`default_nettype none

`include "tile_blit_rect_calc_top_assert.svh"

module tile_blit_rect_calc_top #(
    parameter int unsigned ROW_COUNT_BITS = tbrc_pkg::DEF_ROW_COUNT_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tbrc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [tbrc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [tbrc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    input  wire logic                              cell_valid,
    output logic                                   cell_stall,
    input  wire tbrc_pkg::cell_in_t                cell_data,
    output logic                                   rect_valid,
    input  wire logic                              rect_stall,
    output tbrc_pkg::rect_out_t                    rect
);

    tbrc_pkg::cfg_t                    cfg;
    tbrc_pkg::seq_ctrl_t               ctrl;
    logic                              busy;

    logic [tbrc_pkg::ID_W-1:0]         tile_id;
    logic [tbrc_pkg::ID_W:0]           local_ext;
    logic [tbrc_pkg::ID_W-1:0]         local_idx;
    logic                              enabled;
    logic                              in_range;
    logic                              cell_draw;

    logic                              div_done;
    logic [tbrc_pkg::ID_W-1:0]         quotient;
    logic [tbrc_pkg::COLS_W-1:0]       remainder;

    logic                              draw_reg;
    logic                              final_reg;

    logic [tbrc_pkg::MUL_CNT_W-1:0]    mul_cnt_reg;
    logic [tbrc_pkg::MUL_CNT_W-1:0]    mul_cnt_next;
    logic [tbrc_pkg::MUL_CNT_W-1:0]    prod_idx_reg;
    logic                              mul_last;
    logic [tbrc_pkg::MUL_A_W-1:0]      mul_a;
    logic [tbrc_pkg::PITCH_W-1:0]      mul_b;
    logic [tbrc_pkg::PROD_W-1:0]       prod_reg;
    logic [tbrc_pkg::PITCH_W-1:0]      pitch_x;
    logic [tbrc_pkg::PITCH_W-1:0]      pitch_y;

    logic [tbrc_pkg::SRC_X_W-1:0]      src_x_reg;
    logic [tbrc_pkg::SRC_X_W-1:0]      src_x_next;
    logic [tbrc_pkg::SRC_Y_W-1:0]      src_y_reg;
    logic [tbrc_pkg::SRC_Y_W-1:0]      src_y_next;
    logic [tbrc_pkg::DST_W-1:0]        dst_x_reg;
    logic [tbrc_pkg::DST_W-1:0]        dst_x_next;
    logic [tbrc_pkg::DST_W-1:0]        dst_y_reg;
    logic [tbrc_pkg::DST_W-1:0]        dst_y_next;

    logic [tbrc_pkg::COLS_W-1:0]       cell_col_reg;
    logic [tbrc_pkg::COLS_W-1:0]       cell_col_next;
    logic [ROW_COUNT_BITS-1:0]         cell_row_reg;
    logic [ROW_COUNT_BITS-1:0]         cell_row_next;
    logic [tbrc_pkg::COLS_W:0]         col_inc;

    logic                              out_free;
    logic                              rect_valid_reg;
    logic                              rect_valid_next;
    tbrc_pkg::rect_out_t               rect_reg;
    logic                              skip_zero;

    tbrc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // tile id decode and range check
    assign tile_id   = cell_data.cell_word[tbrc_pkg::ID_W-1:0] &
                       tbrc_pkg::ID_MASK[tbrc_pkg::ID_W-1:0];
    assign local_ext = {1'b0, tile_id} - {1'b0, cfg.first_tile_id};
    assign local_idx = local_ext[tbrc_pkg::ID_W-1:0];
    assign enabled   = (cfg.set_columns != '0) && (cfg.tile_w != '0) &&
                       (cfg.tile_h != '0) && (cfg.layer_cols != '0);
    assign in_range  = !local_ext[tbrc_pkg::ID_W] &&
                       ((cfg.tile_total == '0) || (local_idx < cfg.tile_total));
    assign cell_draw = enabled && in_range;

    tbrc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_draw  (cell_draw),
        .div_done   (div_done),
        .mul_last   (mul_last),
        .out_free   (out_free),
        .busy       (busy),
        .ctrl       (ctrl)
    );

    assign cell_stall = busy;

    tbrc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.div_start),
        .dividend  (local_idx),
        .divisor   (cfg.set_columns),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // per-item flags
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            draw_reg  <= cell_draw;
            final_reg <= cell_data.final_cell;
        end
    end

    // multiplier step counter
    assign mul_last = mul_cnt_reg == tbrc_pkg::MUL_FLUSH;

    always_comb
    begin
        mul_cnt_next = mul_cnt_reg;
        if (ctrl.mul_run)
        begin
            mul_cnt_next = mul_last ? '0 : mul_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_cnt_reg <= '0;
        end
        else
        begin
            mul_cnt_reg <= mul_cnt_next;
        end
    end

    // shared multiplier operand select
    assign pitch_x = tbrc_pkg::PITCH_W'(cfg.tile_w) + tbrc_pkg::PITCH_W'(cfg.tile_gap);
    assign pitch_y = tbrc_pkg::PITCH_W'(cfg.tile_h) + tbrc_pkg::PITCH_W'(cfg.tile_gap);

    always_comb
    begin
        case (mul_cnt_reg)
            tbrc_pkg::MUL_SRC_Y:
            begin
                mul_a = tbrc_pkg::MUL_A_W'(quotient);
                mul_b = pitch_y;
            end
            tbrc_pkg::MUL_SRC_X:
            begin
                mul_a = tbrc_pkg::MUL_A_W'(remainder);
                mul_b = pitch_x;
            end
            tbrc_pkg::MUL_DST_X:
            begin
                mul_a = tbrc_pkg::MUL_A_W'(cell_col_reg);
                mul_b = tbrc_pkg::PITCH_W'(cfg.tile_w);
            end
            tbrc_pkg::MUL_DST_Y:
            begin
                mul_a = tbrc_pkg::MUL_A_W'(cell_row_reg);
                mul_b = tbrc_pkg::PITCH_W'(cfg.tile_h);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= tbrc_pkg::PROD_W'(mul_a) * tbrc_pkg::PROD_W'(mul_b);
        prod_idx_reg <= mul_cnt_reg;
    end

    // result write-back from the registered product
    always_comb
    begin
        src_x_next = src_x_reg;
        src_y_next = src_y_reg;
        dst_x_next = dst_x_reg;
        dst_y_next = dst_y_reg;
        if (ctrl.accept)
        begin
            src_x_next = '0;
            src_y_next = '0;
            dst_x_next = '0;
            dst_y_next = '0;
        end
        else if (ctrl.mul_run && (mul_cnt_reg != tbrc_pkg::MUL_SRC_Y))
        begin
            case (prod_idx_reg)
                tbrc_pkg::MUL_SRC_Y:
                    src_y_next = tbrc_pkg::SRC_Y_W'(cfg.image_margin) +
                                 prod_reg[tbrc_pkg::SRC_Y_W-1:0];
                tbrc_pkg::MUL_SRC_X:
                    src_x_next = tbrc_pkg::SRC_X_W'(cfg.image_margin) +
                                 prod_reg[tbrc_pkg::SRC_X_W-1:0];
                tbrc_pkg::MUL_DST_X:
                    dst_x_next = prod_reg[tbrc_pkg::DST_W-1:0];
                tbrc_pkg::MUL_DST_Y:
                    dst_y_next = prod_reg[tbrc_pkg::DST_W-1:0];
                default:
                    src_x_next = src_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        src_x_reg <= src_x_next;
        src_y_reg <= src_y_next;
        dst_x_reg <= dst_x_next;
        dst_y_reg <= dst_y_next;
    end

    // layer column and row counters, advanced as each result is loaded into the output register
    assign col_inc = {1'b0, cell_col_reg} + 1'b1;

    always_comb
    begin
        cell_col_next = cell_col_reg;
        cell_row_next = cell_row_reg;
        if (ctrl.finish)
        begin
            if (final_reg)
            begin
                cell_col_next = '0;
                cell_row_next = '0;
            end
            else if (col_inc >= {1'b0, cfg.layer_cols})
            begin
                cell_col_next = '0;
                cell_row_next = cell_row_reg + 1'b1;
            end
            else
            begin
                cell_col_next = col_inc[tbrc_pkg::COLS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_col_reg <= '0;
            cell_row_reg <= '0;
        end
        else
        begin
            cell_col_reg <= cell_col_next;
            cell_row_reg <= cell_row_next;
        end
    end

    // output register
    assign out_free = !rect_valid_reg || !rect_stall;

    always_comb
    begin
        rect_valid_next = rect_valid_reg;
        if (ctrl.finish)
        begin
            rect_valid_next = 1'b1;
        end
        else if (rect_valid_reg && !rect_stall)
        begin
            rect_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_valid_reg <= 1'b0;
        end
        else
        begin
            rect_valid_reg <= rect_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            rect_reg.draw         <= draw_reg;
            rect_reg.src_x        <= src_x_reg;
            rect_reg.src_y        <= src_y_reg;
            rect_reg.dst_x        <= dst_x_reg;
            rect_reg.dst_y        <= dst_y_reg;
            rect_reg.end_of_layer <= final_reg;
        end
    end

    assign rect_valid = rect_valid_reg;
    assign rect       = rect_reg;

    // skipped cells carry all-zero rectangle fields
    assign skip_zero = (rect.src_x == '0) && (rect.src_y == '0) &&
                       (rect.dst_x == '0) && (rect.dst_y == '0);

    // checks
    `TBRC_ASSERT_NEXT(a_busy_after_accept, ctrl.accept, cell_stall, "cell taken while busy")
    `TBRC_ASSERT_NEXT(a_mul_after_div, div_done, ctrl.mul_run, "multiply did not follow divide")
    `TBRC_ASSERT_NEXT(a_valid_after_finish, ctrl.finish, rect_valid, "finished result not shown")
    `TBRC_ASSERT_SAME(a_skip_zero, rect_valid && !rect.draw, skip_zero, "skipped cell nonzero")

endmodule

`default_nettype wire

// ===== hw/rtl/tbrc_regs.sv =====
`default_nettype none

module tbrc_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tbrc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [tbrc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [tbrc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output tbrc_pkg::cfg_t                         cfg
);

    tbrc_pkg::cfg_t   cfg_reg;
    tbrc_pkg::cfg_t   cfg_next;
    tbrc_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = tbrc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                tbrc_pkg::REG_FIRST_TILE_ID: cfg_next.first_tile_id = pwdata[tbrc_pkg::ID_W-1:0];
                tbrc_pkg::REG_TILE_TOTAL:    cfg_next.tile_total    = pwdata[tbrc_pkg::ID_W-1:0];
                tbrc_pkg::REG_SET_COLUMNS:   cfg_next.set_columns   = pwdata[tbrc_pkg::COLS_W-1:0];
                tbrc_pkg::REG_TILE_W:        cfg_next.tile_w        = pwdata[tbrc_pkg::PIX_W-1:0];
                tbrc_pkg::REG_TILE_H:        cfg_next.tile_h        = pwdata[tbrc_pkg::PIX_W-1:0];
                tbrc_pkg::REG_IMAGE_MARGIN:  cfg_next.image_margin  = pwdata[tbrc_pkg::PIX_W-1:0];
                tbrc_pkg::REG_TILE_GAP:      cfg_next.tile_gap      = pwdata[tbrc_pkg::PIX_W-1:0];
                tbrc_pkg::REG_LAYER_COLS:    cfg_next.layer_cols    = pwdata[tbrc_pkg::COLS_W-1:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_tile_id <= tbrc_pkg::ID_W'(1);
            cfg_reg.tile_total    <= '0;
            cfg_reg.set_columns   <= tbrc_pkg::COLS_W'(1);
            cfg_reg.tile_w        <= tbrc_pkg::PIX_W'(16);
            cfg_reg.tile_h        <= tbrc_pkg::PIX_W'(16);
            cfg_reg.image_margin  <= '0;
            cfg_reg.tile_gap      <= '0;
            cfg_reg.layer_cols    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register read decode
    always_comb
    begin
        unique case (idx)
            tbrc_pkg::REG_FIRST_TILE_ID: prdata = 32'(cfg_reg.first_tile_id);
            tbrc_pkg::REG_TILE_TOTAL:    prdata = 32'(cfg_reg.tile_total);
            tbrc_pkg::REG_SET_COLUMNS:   prdata = 32'(cfg_reg.set_columns);
            tbrc_pkg::REG_TILE_W:        prdata = 32'(cfg_reg.tile_w);
            tbrc_pkg::REG_TILE_H:        prdata = 32'(cfg_reg.tile_h);
            tbrc_pkg::REG_IMAGE_MARGIN:  prdata = 32'(cfg_reg.image_margin);
            tbrc_pkg::REG_TILE_GAP:      prdata = 32'(cfg_reg.tile_gap);
            tbrc_pkg::REG_LAYER_COLS:    prdata = 32'(cfg_reg.layer_cols);
            default:                     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tbrc_divider.sv =====
`default_nettype none

module tbrc_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tbrc_pkg::ID_W-1:0]     dividend,
    input  wire logic [tbrc_pkg::COLS_W-1:0]   divisor,
    output logic                               done,
    output logic      [tbrc_pkg::ID_W-1:0]     quotient,
    output logic      [tbrc_pkg::COLS_W-1:0]   remainder
);

    logic                              busy_reg;
    logic                              busy_next;
    logic                              done_reg;
    logic                              done_next;
    logic [tbrc_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [tbrc_pkg::DIV_CNT_W-1:0]    cnt_next;
    logic [tbrc_pkg::ID_W-1:0]         quo_reg;
    logic [tbrc_pkg::ID_W-1:0]         quo_next;
    logic [tbrc_pkg::COLS_W-1:0]       rem_reg;
    logic [tbrc_pkg::COLS_W-1:0]       rem_next;
    logic [tbrc_pkg::COLS_W:0]         trial;
    logic [tbrc_pkg::COLS_W:0]         diff;
    logic                              fits;

    // one restoring step: shift in the next dividend bit, try to subtract
    assign trial = {rem_reg, quo_reg[tbrc_pkg::ID_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[tbrc_pkg::ID_W-2:0], fits};
            rem_next = fits ? diff[tbrc_pkg::COLS_W-1:0] : trial[tbrc_pkg::COLS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tbrc_pkg::DIV_CNT_W'(tbrc_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tbrc_seq.sv =====
`default_nettype none

module tbrc_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cell_valid,
    input  wire logic           cell_draw,
    input  wire logic           div_done,
    input  wire logic           mul_last,
    input  wire logic           out_free,
    output logic                busy,
    output tbrc_pkg::seq_ctrl_t ctrl
);

    tbrc_pkg::seq_state_t state_reg;
    tbrc_pkg::seq_state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tbrc_pkg::ST_IDLE:
            begin
                if (cell_valid)
                begin
                    state_next = cell_draw ? tbrc_pkg::ST_DIV : tbrc_pkg::ST_DONE;
                end
            end
            tbrc_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = tbrc_pkg::ST_MUL;
                end
            end
            tbrc_pkg::ST_MUL:
            begin
                if (mul_last)
                begin
                    state_next = tbrc_pkg::ST_DONE;
                end
            end
            tbrc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tbrc_pkg::ST_IDLE;
                end
            end
            default: state_next = tbrc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbrc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control outputs
    always_comb
    begin
        ctrl = '0;
        busy = 1'b1;
        unique case (state_reg)
            tbrc_pkg::ST_IDLE:
            begin
                busy           = 1'b0;
                ctrl.accept    = cell_valid;
                ctrl.div_start = cell_valid && cell_draw;
            end
            tbrc_pkg::ST_DIV:  ctrl = '0;
            tbrc_pkg::ST_MUL:  ctrl.mul_run = 1'b1;
            tbrc_pkg::ST_DONE: ctrl.finish = out_free;
            default:           ctrl = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/tb_tile_blit_rect_calc_top.sv =====
module tb_tile_blit_rect_calc_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROW_BITS = tbrc_pkg::DEF_ROW_COUNT_BITS;
    localparam int unsigned RANDOM_CELLS = 1750;
    localparam int unsigned MAX_WAIT = 18;

    // one line of the directed table: a register write or a cell transfer
    typedef struct {
        bit                  is_cfg;
        tbrc_pkg::reg_idx_t  idx;
        logic [31:0]         value;
        tbrc_pkg::cell_in_t  c;
        bit                  typed;
        tbrc_pkg::rect_out_t want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [tbrc_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [tbrc_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [tbrc_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;
    logic cell_valid = 1'b0;
    logic cell_stall;
    tbrc_pkg::cell_in_t cell_data = '0;
    logic rect_valid;
    logic rect_stall = 1'b0;
    tbrc_pkg::rect_out_t rect;

    // shadow of the register file and the layer cursor
    tbrc_pkg::cfg_t regs;
    logic [tbrc_pkg::COLS_W-1:0] cur_col;
    logic [ROW_BITS-1:0] cur_row;

    tbrc_pkg::rect_out_t pending_rects[$];
    step_t directed_steps[$];

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int unsigned hold_cycles = 0;
    int unsigned errors = 0;
    int unsigned cells_sent = 0;
    int unsigned rects_seen = 0;
    int unsigned drawn_seen = 0;
    int unsigned layers_seen = 0;
    int unsigned cfg_writes = 0;

    tile_blit_rect_calc_top #(
        .ROW_COUNT_BITS(ROW_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .cell_valid(cell_valid),
        .cell_stall(cell_stall),
        .cell_data(cell_data),
        .rect_valid(rect_valid),
        .rect_stall(rect_stall),
        .rect(rect)
    );

    always #6 clk = ~clk;

    // source and destination rectangle of one cell, then step the cursor
    function automatic tbrc_pkg::rect_out_t tile_rect(input tbrc_pkg::cell_in_t c);
        tbrc_pkg::rect_out_t r;
        longint unsigned id_v, first_v, total_v, cols_v, local_idx;
        longint unsigned mg, tw, th, gp, colv, rowv, lcv;
        longint unsigned sx, sy, dx, dy;
        bit enabled;
        r = '0;
        id_v = c.cell_word[tbrc_pkg::ID_W-1:0];
        first_v = regs.first_tile_id;
        total_v = regs.tile_total;
        cols_v = regs.set_columns;
        mg = regs.image_margin;
        tw = regs.tile_w;
        th = regs.tile_h;
        gp = regs.tile_gap;
        colv = cur_col;
        rowv = cur_row;
        lcv = regs.layer_cols;
        enabled = (cols_v != 0) && (tw != 0) && (th != 0) && (lcv != 0);
        // range end is first + total without wrap
        if (enabled && id_v >= first_v && (total_v == 0 || id_v < first_v + total_v))
        begin
            local_idx = id_v - first_v;
            sx = mg + (local_idx % cols_v) * (tw + gp);
            sy = mg + (local_idx / cols_v) * (th + gp);
            dx = colv * tw;
            dy = rowv * th;
            r.draw = 1'b1;
            r.src_x = sx[tbrc_pkg::SRC_X_W-1:0];
            r.src_y = sy[tbrc_pkg::SRC_Y_W-1:0];
            r.dst_x = dx[tbrc_pkg::DST_W-1:0];
            r.dst_y = dy[tbrc_pkg::DST_W-1:0];
        end
        r.end_of_layer = c.final_cell;
        // cursor moves for every cell, drawn or skipped
        if (c.final_cell) begin
            cur_col = '0;
            cur_row = '0;
        end
        else if (colv + 1 >= lcv) begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
        end
        else begin
            cur_col = cur_col + 1'b1;
        end
        return r;
    endfunction

    // apb write, only with nothing in flight
    task automatic write_reg(input tbrc_pkg::reg_idx_t idx, input logic [31:0] value);
        cell_valid <= 1'b0;
        while (pending_rects.size() != 0) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            tbrc_pkg::REG_FIRST_TILE_ID: regs.first_tile_id = value[tbrc_pkg::ID_W-1:0];
            tbrc_pkg::REG_TILE_TOTAL:    regs.tile_total = value[tbrc_pkg::ID_W-1:0];
            tbrc_pkg::REG_SET_COLUMNS:   regs.set_columns = value[tbrc_pkg::COLS_W-1:0];
            tbrc_pkg::REG_TILE_W:        regs.tile_w = value[tbrc_pkg::PIX_W-1:0];
            tbrc_pkg::REG_TILE_H:        regs.tile_h = value[tbrc_pkg::PIX_W-1:0];
            tbrc_pkg::REG_IMAGE_MARGIN:  regs.image_margin = value[tbrc_pkg::PIX_W-1:0];
            tbrc_pkg::REG_TILE_GAP:      regs.tile_gap = value[tbrc_pkg::PIX_W-1:0];
            tbrc_pkg::REG_LAYER_COLS:    regs.layer_cols = value[tbrc_pkg::COLS_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // one cell transfer, after a random gap while tx_idle is set
    task automatic send_cell(input tbrc_pkg::cell_in_t c, input bit typed,
                             input tbrc_pkg::rect_out_t typed_rect);
        tbrc_pkg::rect_out_t predicted;
        int unsigned gap;
        predicted = tile_rect(c);
        gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0) begin
            cell_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_data <= c;
        @(posedge clk);
        while (cell_stall) @(posedge clk);
        pending_rects.push_back(typed ? typed_rect : predicted);
        cells_sent++;
    endtask

    task automatic check_rect(input tbrc_pkg::rect_out_t got);
        tbrc_pkg::rect_out_t want;
        if (pending_rects.size() == 0) begin
            $error("rect transfer with no cell pending");
            errors++;
            return;
        end
        want = pending_rects.pop_front();
        rects_seen++;
        if (got.draw) drawn_seen++;
        if (got.end_of_layer) layers_seen++;
        if (got.draw !== want.draw) begin
            $error("draw: expected %0d, got %0d", want.draw, got.draw);
            errors++;
        end
        if (got.src_x !== want.src_x) begin
            $error("src_x: expected %0h, got %0h", want.src_x, got.src_x);
            errors++;
        end
        if (got.src_y !== want.src_y) begin
            $error("src_y: expected %0h, got %0h", want.src_y, got.src_y);
            errors++;
        end
        if (got.dst_x !== want.dst_x) begin
            $error("dst_x: expected %0h, got %0h", want.dst_x, got.dst_x);
            errors++;
        end
        if (got.dst_y !== want.dst_y) begin
            $error("dst_y: expected %0h, got %0h", want.dst_y, got.dst_y);
            errors++;
        end
        if (got.end_of_layer !== want.end_of_layer) begin
            $error("end_of_layer: expected %0d, got %0d", want.end_of_layer, got.end_of_layer);
            errors++;
        end
    endtask

    // rect receiver: check each transfer, then hold off the next result a while if rx_idle is set
    always @(posedge clk) begin
        if (rst_n) begin
            if (rect_valid && !rect_stall) begin
                check_rect(rect);
                hold_cycles = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
            end
            else if (rect_valid && hold_cycles != 0) begin
                hold_cycles--;
            end
            rect_stall <= (hold_cycles != 0);
        end
    end

    // directed table builders
    function automatic void add_cfg(input tbrc_pkg::reg_idx_t idx, input logic [31:0] value);
        step_t s;
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.value = value;
        s.c = '0;
        s.typed = 1'b0;
        s.want = '0;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_row(input tbrc_pkg::cell_in_t c, input bit typed,
                                    input tbrc_pkg::rect_out_t want);
        step_t s;
        s.is_cfg = 1'b0;
        s.idx = tbrc_pkg::REG_FIRST_TILE_ID;
        s.value = '0;
        s.c = c;
        s.typed = typed;
        s.want = want;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_cell(input logic [31:0] word, input logic fin);
        add_row(tbrc_pkg::cell_in_t'{word, fin}, 1'b0, '0);
    endfunction

    // skipped cell: all rectangle fields zero, end flag echoed
    function automatic void add_skip(input logic [31:0] word, input logic fin);
        tbrc_pkg::rect_out_t w;
        w = '0;
        w.end_of_layer = fin;
        add_row(tbrc_pkg::cell_in_t'{word, fin}, 1'b1, w);
    endfunction

    function automatic void build_directed();
        // after reset layer_cols is zero, so nothing is drawn
        add_skip(32'h0000_0001, 1'b0);
        add_skip(32'hFFFF_FFFF, 1'b1);
        // widest tile height, margin and gap, unbounded tileset
        add_cfg(tbrc_pkg::REG_LAYER_COLS, 32'd3);
        add_cfg(tbrc_pkg::REG_SET_COLUMNS, 32'd4);
        add_cfg(tbrc_pkg::REG_TILE_W, 32'd8);
        add_cfg(tbrc_pkg::REG_TILE_H, 32'hFFF);
        add_cfg(tbrc_pkg::REG_IMAGE_MARGIN, 32'hFFF);
        add_cfg(tbrc_pkg::REG_TILE_GAP, 32'hFFF);
        add_cfg(tbrc_pkg::REG_FIRST_TILE_ID, 32'd1);
        add_cfg(tbrc_pkg::REG_TILE_TOTAL, 32'd0);
        add_row(tbrc_pkg::cell_in_t'{32'hE000_0001, 1'b0}, 1'b1,
                tbrc_pkg::rect_out_t'{1'b1, 32'd4095, 43'd4095, 28'd0, 28'd0, 1'b0});
        add_cell(32'h1FFF_FFFF, 1'b0);
        add_skip(32'h0000_0000, 1'b0);
        add_cell(32'h0000_0005, 1'b1);
        // bounded range, both ends
        add_cfg(tbrc_pkg::REG_FIRST_TILE_ID, 32'd10);
        add_cfg(tbrc_pkg::REG_TILE_TOTAL, 32'd3);
        add_skip(32'd9, 1'b0);
        add_cell(32'd10, 1'b0);
        add_cell(32'd12, 1'b0);
        add_skip(32'd13, 1'b0);
        // range end past 29 bits must not wrap
        add_cfg(tbrc_pkg::REG_FIRST_TILE_ID, 32'h1FFF_FFFF);
        add_cfg(tbrc_pkg::REG_TILE_TOTAL, 32'h1FFF_FFFF);
        add_cell(32'h3FFF_FFFF, 1'b0);
        add_skip(32'h1FFF_FFFE, 1'b0);
        // widest column counts and tile size
        add_cfg(tbrc_pkg::REG_FIRST_TILE_ID, 32'd0);
        add_cfg(tbrc_pkg::REG_TILE_TOTAL, 32'd0);
        add_cfg(tbrc_pkg::REG_SET_COLUMNS, 32'hFFFF);
        add_cfg(tbrc_pkg::REG_TILE_W, 32'hFFF);
        add_cfg(tbrc_pkg::REG_LAYER_COLS, 32'hFFFF);
        add_cfg(tbrc_pkg::REG_IMAGE_MARGIN, 32'd0);
        add_cfg(tbrc_pkg::REG_TILE_GAP, 32'd0);
        add_cell(32'h5FFF_FFFF, 1'b0);
        add_cell(32'h8000_0000, 1'b1);
        // each zero size turns drawing off, cursor keeps moving
        add_cfg(tbrc_pkg::REG_SET_COLUMNS, 32'd0);
        add_skip(32'd5, 1'b0);
        add_cfg(tbrc_pkg::REG_SET_COLUMNS, 32'd1);
        add_cfg(tbrc_pkg::REG_TILE_W, 32'd0);
        add_skip(32'd6, 1'b0);
        add_cfg(tbrc_pkg::REG_TILE_W, 32'd1);
        add_cfg(tbrc_pkg::REG_TILE_H, 32'd0);
        add_skip(32'd7, 1'b0);
        // row wrap, then layer width lowered below the current column
        add_cfg(tbrc_pkg::REG_TILE_H, 32'd3);
        add_cfg(tbrc_pkg::REG_LAYER_COLS, 32'd5);
        repeat (5) add_cell(32'd8, 1'b0);
        add_cfg(tbrc_pkg::REG_LAYER_COLS, 32'd1);
        add_cell(32'd9, 1'b0);
        add_cell(32'd10, 1'b1);
    endfunction

    // register value: zero, full scale, small or random, sometimes with junk above
    function automatic logic [31:0] cfg_pick(input int unsigned width,
                                             input int unsigned zero_odds);
        logic [31:0] mask;
        logic [31:0] v;
        int unsigned k;
        mask = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
        k = $urandom_range(0, 15);
        if (k < zero_odds) v = '0;
        else if (k < zero_odds + 2) v = mask;
        else if (k < 11) v = $urandom_range(1, 24);
        else v = $urandom & mask;
        if ($urandom_range(0, 7) == 0) v = v | ($urandom & ~mask);
        return v;
    endfunction

    // cell word mostly inside the tileset range, some at its edges, some raw
    function automatic tbrc_pkg::cell_in_t rand_cell(input bit last);
        tbrc_pkg::cell_in_t c;
        longint unsigned first_v, span, id_v;
        logic [2:0] flips;
        int unsigned k;
        first_v = regs.first_tile_id;
        span = (regs.tile_total == 0) ? 64'd4096 : regs.tile_total;
        k = $urandom_range(0, 9);
        flips = 3'($urandom_range(0, 7));
        if (k == 1) id_v = first_v + span;
        else if (k == 2) id_v = (first_v == 0) ? 64'd0 : first_v - 1;
        else if (k == 3) id_v = first_v + span - 1;
        else id_v = first_v + $urandom_range(0, int'(span - 1));
        c.cell_word = {flips, id_v[tbrc_pkg::ID_W-1:0]};
        if (k == 0) c.cell_word = $urandom;
        c.final_cell = last ? 1'b1 : ($urandom_range(0, 19) == 0);
        return c;
    endfunction

    initial begin
        int unsigned random_cells;
        int unsigned len;
        int unsigned lc;
        regs.first_tile_id = 1;
        regs.tile_total = 0;
        regs.set_columns = 1;
        regs.tile_w = 16;
        regs.tile_h = 16;
        regs.image_margin = 0;
        regs.tile_gap = 0;
        regs.layer_cols = 0;
        cur_col = '0;
        cur_row = '0;
        random_cells = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        build_directed();
        foreach (directed_steps[i]) begin
            if (directed_steps[i].is_cfg)
                write_reg(directed_steps[i].idx, directed_steps[i].value);
            else
                send_cell(directed_steps[i].c, directed_steps[i].typed, directed_steps[i].want);
        end

        // random phases: new settings, then a few well-formed layers
        while (random_cells < RANDOM_CELLS) begin
            write_reg(tbrc_pkg::REG_FIRST_TILE_ID, cfg_pick(tbrc_pkg::ID_W, 2));
            write_reg(tbrc_pkg::REG_TILE_TOTAL, cfg_pick(tbrc_pkg::ID_W, 4));
            write_reg(tbrc_pkg::REG_SET_COLUMNS, cfg_pick(tbrc_pkg::COLS_W, 1));
            write_reg(tbrc_pkg::REG_TILE_W, cfg_pick(tbrc_pkg::PIX_W, 1));
            write_reg(tbrc_pkg::REG_TILE_H, cfg_pick(tbrc_pkg::PIX_W, 1));
            write_reg(tbrc_pkg::REG_IMAGE_MARGIN, cfg_pick(tbrc_pkg::PIX_W, 3));
            write_reg(tbrc_pkg::REG_TILE_GAP, cfg_pick(tbrc_pkg::PIX_W, 3));
            write_reg(tbrc_pkg::REG_LAYER_COLS, cfg_pick(tbrc_pkg::COLS_W, 1));
            repeat ($urandom_range(2, 6)) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
                lc = regs.layer_cols;
                len = (lc == 0 || lc > 12) ? $urandom_range(1, 24) : $urandom_range(1, 3 * lc + 1);
                for (int n = 0; n < len; n++)
                    send_cell(rand_cell(n == len - 1), 1'b0, '0);
                random_cells += len;
            end
        end

        // a skipped layer end, then one drawn cell per row at the tallest tile, back to back
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        write_reg(tbrc_pkg::REG_FIRST_TILE_ID, 32'd1);
        write_reg(tbrc_pkg::REG_TILE_TOTAL, 32'd0);
        write_reg(tbrc_pkg::REG_SET_COLUMNS, 32'd1);
        write_reg(tbrc_pkg::REG_TILE_W, 32'd1);
        write_reg(tbrc_pkg::REG_TILE_H, 32'hFFF);
        write_reg(tbrc_pkg::REG_LAYER_COLS, 32'd1);
        send_cell(tbrc_pkg::cell_in_t'{32'd0, 1'b1}, 1'b0, '0);
        repeat (40) send_cell(tbrc_pkg::cell_in_t'{32'd1, 1'b0}, 1'b0, '0);
        send_cell(tbrc_pkg::cell_in_t'{32'd1, 1'b1}, 1'b0, '0);

        // drain
        cell_valid <= 1'b0;
        while (pending_rects.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d cells sent, %0d results checked: %0d drawn, %0d layer ends",
                 cells_sent, rects_seen, drawn_seen, layers_seen);
        $display("%0d register writes over random settings and back to back tall rows",
                 cfg_writes);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit
    initial begin
        #(3_000_000 * 12);
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== tile_blit_rect_calc_top.f =====
+incdir+hw/rtl
hw/rtl/tbrc_pkg.sv
hw/rtl/tbrc_regs.sv
hw/rtl/tbrc_divider.sv
hw/rtl/tbrc_seq.sv
hw/rtl/tile_blit_rect_calc_top.sv
tb/tb_tile_blit_rect_calc_top.sv
